### design/rht_pkg.sv
// Shared types and constants for the reference-counted handle table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rht_pkg;

  localparam int CW     = 16;
  localparam int IDX_W  = 6;
  localparam int DEV_W  = 2;
  localparam int REQ_W  = 3;
  localparam int HND_W  = 64;
  localparam int KIND_W = 2;
  localparam int ST_W   = 2;
  localparam int DATA_W = 80;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ASSIGN  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PHASE   = 3'd4;

  localparam logic [ST_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [ST_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [ST_W-1:0] STATUS_NULL = 2'd2;
  localparam logic [ST_W-1:0] STATUS_ERR  = 2'd3;

  localparam logic [IDX_W-1:0] WALK_LIMIT = 6'd63;
  localparam logic [CW-1:0]    COUNT_MAX  = 16'hFFFF;
  localparam logic [CW-1:0]    COUNT_ONE  = 16'd1;

  typedef enum logic [1:0] {
    CNT_INC = 2'b01,
    CNT_DEC = 2'b10
  } cnt_op_t;

  typedef struct packed {
    logic rd_en;
    logic cl_we;
    logic hd_we;
  } mem_ctl_t;

endpackage

### design/rht_mem.sv
// Slot storage: count/link words with a live flag, and the handle store.
// Uses rht_pkg for the control struct and word widths.
`timescale 1ns / 1ps

module rht_mem #(
  parameter int SLOT_COUNT = 64,
  parameter int AW         = 6
) (
  input  logic                      clk,
  input  rht_pkg::mem_ctl_t         ctl,
  input  logic [AW-1:0]             raddr,
  input  logic [AW-1:0]             waddr,
  input  logic [rht_pkg::CW:0]      cl_wdata,
  input  logic [rht_pkg::HND_W-1:0] hd_wdata,
  output logic [rht_pkg::CW:0]      cl_rdata,
  output logic [rht_pkg::HND_W-1:0] hd_rdata
);

  logic [rht_pkg::CW:0]      cl_mem [SLOT_COUNT];
  logic [rht_pkg::HND_W-1:0] hd_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (ctl.cl_we) begin
      cl_mem[waddr] <= cl_wdata;
    end
    if (ctl.rd_en) begin
      cl_rdata <= cl_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hd_we) begin
      hd_mem[waddr] <= hd_wdata;
    end
    if (ctl.rd_en) begin
      hd_rdata <= hd_mem[raddr];
    end
  end

endmodule

### design/rht_cnt_unit.sv
// Shared 16-bit increment/decrement unit with limit detect.
// Uses rht_pkg for the operation type and word width.
`timescale 1ns / 1ps

module rht_cnt_unit (
  input  rht_pkg::cnt_op_t       op,
  input  logic [rht_pkg::CW-1:0] operand,
  output logic [rht_pkg::CW-1:0] result,
  output logic                   at_limit
);

  always_comb begin
    unique case (op)
      rht_pkg::CNT_INC: begin
        result   = operand + rht_pkg::COUNT_ONE;
        at_limit = (operand == rht_pkg::COUNT_MAX);
      end
      rht_pkg::CNT_DEC: begin
        result   = operand - rht_pkg::COUNT_ONE;
        at_limit = (operand == '0);
      end
      default: begin
        result   = operand;
        at_limit = 1'b0;
      end
    endcase
  end

endmodule

### design/refcounted_handle_table_deferred_free.sv
// Reference-counted slot table with a free list and per-device phased release
// lists. Uses rht_pkg, rht_mem and rht_cnt_unit.
//
// One request is taken at a time; s_tready is high only while the sequencer
// is idle, and a finished result may still wait in the output register. An
// add decodes and, when it pops the free list, first reads the list head; an
// acquire or release reads the slot and then writes the new count unless the
// id check alone decides (null id, never-used slot or bad device); an assign
// runs a release of one id and then an acquire of the other, and does nothing
// when both ids are equal; a next phase frees one slot of the oldest list per
// output word. Any request waits while the output side stalls. The pace is
// set by the slot memory with a registered read (one read-modify-write of a
// slot per request step) and by the one shared count unit. Slot liveness is
// kept as a flag bit in the slot word and slots at or above the never-used
// mark are treated as not live, so no clearing pass is needed after reset.
`timescale 1ns / 1ps

module refcounted_handle_table_deferred_free #(
  parameter int SLOT_COUNT   = 64,
  parameter int DEVICE_COUNT = 4,
  parameter int PHASE_COUNT  = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_wdata,    // object_kind
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] device_index, [7:2] object_index, [13:8] other_index,
  // [77:14] handle_value, [79:78] zero
  input  logic [79:0] s_tdata,
  input  logic [2:0]  s_tuser,      // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  // [5:0] slot_index, [7:6] device_echo, [71:8] freed_handle,
  // [73:72] kind_echo, [75:74] status, [79:76] zero
  output logic [79:0] m_tdata,
  output logic [0:0]  m_tuser,      // [0] is_destroy
  output logic        m_tlast
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int DW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int CW = rht_pkg::CW;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DECODE  = 7'b0000010,
    ST_ADD_POP = 7'b0000100,
    ST_CNT_RD  = 7'b0001000,
    ST_CNT_EX  = 7'b0010000,
    ST_DONE    = 7'b0100000,
    ST_PH_EM   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [rht_pkg::REQ_W-1:0]  req;
  logic [rht_pkg::DEV_W-1:0]  dev;
  logic [rht_pkg::IDX_W-1:0]  obj;
  logic [rht_pkg::IDX_W-1:0]  oth;
  logic [rht_pkg::HND_W-1:0]  handle;
  logic [rht_pkg::KIND_W-1:0] kind;

  logic [AW-1:0] free_head, free_head_next;
  logic [AW:0]   used_mark, used_mark_next;
  logic [AW-1:0] heads [DEVICE_COUNT][PHASE_COUNT];

  logic [rht_pkg::IDX_W-1:0] op_idx, op_idx_next;
  logic                      op_acq, op_acq_next;
  logic                      pend_acq, pend_acq_next;
  logic [AW-1:0]             cur_id, cur_id_next;
  logic [rht_pkg::IDX_W-1:0] walk_n, walk_n_next;
  logic [AW-1:0]             slot_res, slot_res_next;
  logic [rht_pkg::ST_W-1:0]  status_res, status_res_next;

  logic [rht_pkg::IDX_W-1:0]  out_slot;
  logic [rht_pkg::DEV_W-1:0]  out_dev;
  logic [rht_pkg::HND_W-1:0]  out_handle;
  logic [rht_pkg::KIND_W-1:0] out_kind;
  logic [rht_pkg::ST_W-1:0]   out_status;
  logic                       out_destroy;
  logic                       out_last;

  logic                      emit;
  logic [AW-1:0]             emit_slot;
  logic [rht_pkg::HND_W-1:0] emit_handle;
  logic                      emit_destroy;
  logic [rht_pkg::ST_W-1:0]  emit_status;
  logic                      emit_last;

  logic          head_shift;
  logic          head0_wr;
  logic [AW-1:0] head0_val;
  logic          tail_wr;
  logic [AW-1:0] tail_val;

  rht_pkg::mem_ctl_t         mem_ctl;
  logic [AW-1:0]             mem_raddr;
  logic [AW-1:0]             mem_waddr;
  logic [CW:0]               cl_wdata;
  logic [rht_pkg::HND_W-1:0] hd_wdata;
  logic [CW:0]               cl_rdata;
  logic [rht_pkg::HND_W-1:0] hd_rdata;

  rht_pkg::cnt_op_t cnt_op;
  logic [CW-1:0]    cnt_operand;
  logic [CW-1:0]    cnt_result;
  logic             cnt_at_limit;

  logic          out_free;
  logic          dev_bad;
  logic [DW-1:0] dev_row;
  logic [AW-1:0] link_chk;
  logic [rht_pkg::ST_W-1:0] op_st;
  logic          op_finish;

  rht_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .AW         (AW)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .raddr    (mem_raddr),
    .waddr    (mem_waddr),
    .cl_wdata (cl_wdata),
    .hd_wdata (hd_wdata),
    .cl_rdata (cl_rdata),
    .hd_rdata (hd_rdata)
  );

  rht_cnt_unit u_cnt (
    .op       (cnt_op),
    .operand  (cnt_operand),
    .result   (cnt_result),
    .at_limit (cnt_at_limit)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign dev_bad  = (32'(dev) >= DEVICE_COUNT);
  assign dev_row  = DW'(dev);
  assign link_chk = (32'(cl_rdata[CW-1:0]) >= SLOT_COUNT) ? '0 : AW'(cl_rdata[CW-1:0]);

  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    used_mark_next  = used_mark;
    op_idx_next     = op_idx;
    op_acq_next     = op_acq;
    pend_acq_next   = pend_acq;
    cur_id_next     = cur_id;
    walk_n_next     = walk_n;
    slot_res_next   = slot_res;
    status_res_next = status_res;

    emit         = 1'b0;
    emit_slot    = slot_res;
    emit_handle  = '0;
    emit_destroy = 1'b0;
    emit_status  = status_res;
    emit_last    = 1'b1;

    head_shift = 1'b0;
    head0_wr   = 1'b0;
    head0_val  = '0;
    tail_wr    = 1'b0;
    tail_val   = '0;

    mem_ctl   = '0;
    mem_raddr = '0;
    mem_waddr = '0;
    cl_wdata  = '0;
    hd_wdata  = handle;

    cnt_op      = rht_pkg::CNT_INC;
    cnt_operand = '0;

    op_finish = 1'b0;
    op_st     = rht_pkg::STATUS_OK;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        status_res_next = rht_pkg::STATUS_OK;
        slot_res_next   = '0;
        state_next      = ST_DONE;
        case (req)
          rht_pkg::REQ_ADD: begin
            if (dev_bad) begin
              status_res_next = rht_pkg::STATUS_ERR;
            end else if (free_head != '0) begin
              mem_ctl.rd_en = 1'b1;
              mem_raddr     = free_head;
              state_next    = ST_ADD_POP;
            end else if (32'(used_mark) < SLOT_COUNT) begin
              cnt_operand    = CW'(used_mark);
              used_mark_next = (AW + 1)'(cnt_result);
              mem_ctl.cl_we  = 1'b1;
              mem_ctl.hd_we  = 1'b1;
              mem_waddr      = AW'(used_mark);
              cl_wdata       = {1'b1, rht_pkg::COUNT_ONE};
              slot_res_next  = AW'(used_mark);
            end else begin
              status_res_next = rht_pkg::STATUS_FULL;
            end
          end
          rht_pkg::REQ_ACQUIRE: begin
            op_acq_next   = 1'b1;
            pend_acq_next = 1'b0;
            op_idx_next   = obj;
            state_next    = ST_CNT_RD;
          end
          rht_pkg::REQ_RELEASE: begin
            op_acq_next   = 1'b0;
            pend_acq_next = 1'b0;
            op_idx_next   = obj;
            state_next    = ST_CNT_RD;
          end
          rht_pkg::REQ_ASSIGN: begin
            if (obj != oth) begin
              op_acq_next   = 1'b0;
              pend_acq_next = 1'b1;
              op_idx_next   = obj;
              state_next    = ST_CNT_RD;
            end
          end
          rht_pkg::REQ_PHASE: begin
            if (dev_bad) begin
              status_res_next = rht_pkg::STATUS_ERR;
            end else if (heads[dev_row][0] == '0) begin
              head_shift = 1'b1;
            end else begin
              cur_id_next   = heads[dev_row][0];
              walk_n_next   = '0;
              mem_ctl.rd_en = 1'b1;
              mem_raddr     = heads[dev_row][0];
              state_next    = ST_PH_EM;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end

      ST_ADD_POP: begin
        free_head_next = link_chk;
        mem_ctl.cl_we  = 1'b1;
        mem_ctl.hd_we  = 1'b1;
        mem_waddr      = free_head;
        cl_wdata       = {1'b1, rht_pkg::COUNT_ONE};
        slot_res_next  = free_head;
        state_next     = ST_DONE;
      end

      ST_CNT_RD: begin
        if (op_idx == '0) begin
          op_finish = 1'b1;
          op_st     = op_acq ? rht_pkg::STATUS_NULL : rht_pkg::STATUS_OK;
        end else if ((32'(op_idx) >= SLOT_COUNT) || (32'(op_idx) >= 32'(used_mark)) ||
                     (!op_acq && dev_bad)) begin
          op_finish = 1'b1;
          op_st     = rht_pkg::STATUS_ERR;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = AW'(op_idx);
          state_next    = ST_CNT_EX;
        end
      end

      ST_CNT_EX: begin
        cnt_op      = op_acq ? rht_pkg::CNT_INC : rht_pkg::CNT_DEC;
        cnt_operand = cl_rdata[CW-1:0];
        op_finish   = 1'b1;
        mem_waddr   = AW'(op_idx);
        if (!cl_rdata[CW] || cnt_at_limit) begin
          op_st = rht_pkg::STATUS_ERR;
        end else if (!op_acq && (cnt_result == '0)) begin
          mem_ctl.cl_we = 1'b1;
          cl_wdata      = {1'b0, CW'(heads[dev_row][PHASE_COUNT-1])};
          tail_wr       = 1'b1;
          tail_val      = AW'(op_idx);
        end else begin
          mem_ctl.cl_we = 1'b1;
          cl_wdata      = {1'b1, cnt_result};
        end
      end

      ST_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_PH_EM: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_slot      = cur_id;
          emit_handle    = hd_rdata;
          emit_destroy   = 1'b1;
          emit_status    = rht_pkg::STATUS_OK;
          emit_last      = (link_chk == '0) || (walk_n == rht_pkg::WALK_LIMIT - 6'd1);
          mem_ctl.cl_we  = 1'b1;
          mem_waddr      = cur_id;
          cl_wdata       = {1'b0, CW'(free_head)};
          free_head_next = cur_id;
          walk_n_next    = walk_n + 6'd1;
          cur_id_next    = link_chk;
          if (emit_last) begin
            state_next = ST_IDLE;
            if (link_chk != '0) begin
              head0_wr  = 1'b1;
              head0_val = link_chk;
            end else begin
              head_shift = 1'b1;
            end
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = link_chk;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // combine statuses: the first non-ok one wins; an assign continues with its acquire
    if (op_finish) begin
      if (status_res == rht_pkg::STATUS_OK) begin
        status_res_next = op_st;
      end
      if (pend_acq) begin
        pend_acq_next = 1'b0;
        op_acq_next   = 1'b1;
        op_idx_next   = oth;
        state_next    = ST_CNT_RD;
      end else begin
        state_next = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= '0;
      used_mark <= (AW + 1)'(1);
      kind      <= '0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      used_mark <= used_mark_next;
      if (cfg_wen) begin
        kind <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DEVICE_COUNT; d++) begin
        for (int p = 0; p < PHASE_COUNT; p++) begin
          heads[d][p] <= '0;
        end
      end
    end else begin
      if (head_shift) begin
        for (int p = 0; p < PHASE_COUNT - 1; p++) begin
          heads[dev_row][p] <= heads[dev_row][p+1];
        end
        heads[dev_row][PHASE_COUNT-1] <= '0;
      end
      if (head0_wr) begin
        heads[dev_row][0] <= head0_val;
      end
      if (tail_wr) begin
        heads[dev_row][PHASE_COUNT-1] <= tail_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req    <= s_tuser;
      dev    <= s_tdata[1:0];
      obj    <= s_tdata[7:2];
      oth    <= s_tdata[13:8];
      handle <= s_tdata[77:14];
    end
    op_idx     <= op_idx_next;
    op_acq     <= op_acq_next;
    pend_acq   <= pend_acq_next;
    cur_id     <= cur_id_next;
    walk_n     <= walk_n_next;
    slot_res   <= slot_res_next;
    status_res <= status_res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_slot    <= rht_pkg::IDX_W'(emit_slot);
      out_dev     <= dev;
      out_handle  <= emit_handle;
      out_kind    <= kind;
      out_status  <= emit_status;
      out_destroy <= emit_destroy;
      out_last    <= emit_last;
    end
  end

  assign m_tdata = {4'b0000, out_status, out_kind, out_handle, out_dev, out_slot};
  assign m_tuser = out_destroy;
  assign m_tlast = out_last;

  a_free_head_used : assert property (@(posedge clk) disable iff (rst)
    (free_head != '0) |-> ({1'b0, free_head} < used_mark))
    else $error("free list head beyond never-used mark");

  a_walk_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_PH_EM) |-> (walk_n < rht_pkg::WALK_LIMIT))
    else $error("phase walk past its limit");

  a_emit_room : assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result loaded while output word still held");

  a_accept_decode : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DECODE) && !s_tready)
    else $error("accepted word not taken into decode");

endmodule
